// File: hdl/ry420_pkg.sv
// Package: payload types and fixed-point BT.601 weights for the RGB to YCbCr 4:2:0 block.
package ry420_pkg;

    // One 2x2 block of RGB pixels: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
    typedef struct packed {
        logic [7:0] p0_red;
        logic [7:0] p0_green;
        logic [7:0] p0_blue;
        logic [7:0] p1_red;
        logic [7:0] p1_green;
        logic [7:0] p1_blue;
        logic [7:0] p2_red;
        logic [7:0] p2_green;
        logic [7:0] p2_blue;
        logic [7:0] p3_red;
        logic [7:0] p3_green;
        logic [7:0] p3_blue;
    } t_rgb_blk;

    typedef struct packed {
        logic [7:0] luma0;
        logic [7:0] luma1;
        logic [7:0] luma2;
        logic [7:0] luma3;
        logic [7:0] blue_chroma;
        logic [7:0] red_chroma;
    } t_ycc_blk;

    // Widths of the fixed-point sums (units of 2^-16)
    localparam int unsigned LUMA_W   = 25;  // offset + weighted sum + rounding, below 2^25
    localparam int unsigned CHROMA_W = 28;  // signed total over four pixels

    // Luma weights, c/255 * 2^16 rounded
    localparam logic [LUMA_W-1:0] Y_WR = LUMA_W'(16829);
    localparam logic [LUMA_W-1:0] Y_WG = LUMA_W'(33039);
    localparam logic [LUMA_W-1:0] Y_WB = LUMA_W'(6416);
    localparam logic [LUMA_W-1:0] Y_OFS_RND = LUMA_W'(16 * 65536 + 32768);

    // Chroma weights
    localparam logic signed [CHROMA_W-1:0] CB_WR = -CHROMA_W'(9714);
    localparam logic signed [CHROMA_W-1:0] CB_WG = -CHROMA_W'(19070);
    localparam logic signed [CHROMA_W-1:0] CB_WB = CHROMA_W'(28784);
    localparam logic signed [CHROMA_W-1:0] CR_WR = CHROMA_W'(28784);
    localparam logic signed [CHROMA_W-1:0] CR_WG = -CHROMA_W'(24103);
    localparam logic signed [CHROMA_W-1:0] CR_WB = -CHROMA_W'(4681);
    // Four offsets of 128 plus half an LSB of the mean (2^17)
    localparam logic signed [CHROMA_W-1:0] C_OFS4_RND = CHROMA_W'(4 * 128 * 65536 + 131072);

endpackage

// File: hdl/ry420_calc.sv
// Combinational datapath: four luma values and averaged Cb/Cr from one 2x2 RGB block.
module ry420_calc (
    input  ry420_pkg::t_rgb_blk i_blk,
    output ry420_pkg::t_ycc_blk o_ycc
);
    import ry420_pkg::*;

    logic [LUMA_W-1:0]          w_y0, w_y1, w_y2, w_y3;
    logic [9:0]                 w_sum_r, w_sum_g, w_sum_b;
    logic signed [CHROMA_W-1:0] w_sr, w_sg, w_sb;
    logic signed [CHROMA_W-1:0] w_cb, w_cr;

    function automatic logic [LUMA_W-1:0] luma_sum(
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        return Y_OFS_RND + Y_WR * LUMA_W'(r) + Y_WG * LUMA_W'(g) + Y_WB * LUMA_W'(b);
    endfunction

    assign w_y0 = luma_sum(i_blk.p0_red, i_blk.p0_green, i_blk.p0_blue);
    assign w_y1 = luma_sum(i_blk.p1_red, i_blk.p1_green, i_blk.p1_blue);
    assign w_y2 = luma_sum(i_blk.p2_red, i_blk.p2_green, i_blk.p2_blue);
    assign w_y3 = luma_sum(i_blk.p3_red, i_blk.p3_green, i_blk.p3_blue);

    // Chroma is linear: weight the channel sums once instead of per pixel
    assign w_sum_r = 10'(i_blk.p0_red) + 10'(i_blk.p1_red)
                   + 10'(i_blk.p2_red) + 10'(i_blk.p3_red);
    assign w_sum_g = 10'(i_blk.p0_green) + 10'(i_blk.p1_green)
                   + 10'(i_blk.p2_green) + 10'(i_blk.p3_green);
    assign w_sum_b = 10'(i_blk.p0_blue) + 10'(i_blk.p1_blue)
                   + 10'(i_blk.p2_blue) + 10'(i_blk.p3_blue);

    assign w_sr = $signed({{(CHROMA_W-10){1'b0}}, w_sum_r});
    assign w_sg = $signed({{(CHROMA_W-10){1'b0}}, w_sum_g});
    assign w_sb = $signed({{(CHROMA_W-10){1'b0}}, w_sum_b});

    assign w_cb = C_OFS4_RND + CB_WR * w_sr + CB_WG * w_sg + CB_WB * w_sb;
    assign w_cr = C_OFS4_RND + CR_WR * w_sr + CR_WG * w_sg + CR_WB * w_sb;

    // Totals stay positive and below 2^26; mean = total / 4 / 2^16
    assign o_ycc.luma0       = w_y0[23:16];
    assign o_ycc.luma1       = w_y1[23:16];
    assign o_ycc.luma2       = w_y2[23:16];
    assign o_ycc.luma3       = w_y3[23:16];
    assign o_ycc.blue_chroma = w_cb[25:18];
    assign o_ycc.red_chroma  = w_cr[25:18];

endmodule

// File: hdl/rgb_to_ycbcr420_block.sv
// Top level: BT.601 RGB to YCbCr 4:2:0 converter with input and result registers.
// Each item is one 2x2 block of 8-bit RGB pixels; each result is four studio-range
// luma values (16..235) and one Cb and one Cr (16..240), each chroma value the
// rounded mean of the four pixels. Weights are c/255 scaled by 2^16 and rounded,
// halves round up. The block is a two-register pipeline: an item is captured in the
// input register, converted by one pass of constant-weight multiply-add logic, and
// lands in the result register once that register is free, which raises o_out_valid.
// One item is accepted every clock while the output is not stalled.
// Both registers hold under back-pressure, so up to two items are in flight.
// No state or configuration; reset only clears the valid flags.
module rgb_to_ycbcr420_block (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ry420_pkg::t_rgb_blk   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ry420_pkg::t_ycc_blk   o_out_data
);
    import ry420_pkg::*;

    // Input stage
    logic     r_in_vld, n_in_vld;
    t_rgb_blk r_in;
    // Result stage
    logic     r_out_vld, n_out_vld;
    t_ycc_blk r_out;

    logic     w_out_adv;   // result register may load
    logic     w_in_adv;    // input register may load
    t_ycc_blk w_ycc;

    ry420_calc u_calc (
        .i_blk (r_in),
        .o_ycc (w_ycc)
    );

    // A stage moves when it is empty or its content moves on
    assign w_out_adv = !r_out_vld || !i_out_stall;
    assign w_in_adv  = !r_in_vld || w_out_adv;

    assign n_out_vld = w_out_adv ? r_in_vld : r_out_vld;
    assign n_in_vld  = w_in_adv ? i_in_valid : r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_adv) begin
            r_in <= i_in_data;
        end
        if (w_out_adv) begin
            r_out <= w_ycc;
        end
    end

    assign o_in_stall  = !w_in_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Stall upstream only when both stages hold an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled while pipeline has room");

    // An accepted item reaches the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_vld)
        else $error("accepted item lost at input register");

    // An item in the input register moves to the output when the output is free
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && w_out_adv) |=> o_out_valid)
        else $error("item dropped between stages");

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule
